FILE: hw/rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// Raster spatial predictor package
// Shared widths, register indexes, codes and prediction arithmetic.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int EXT_W      = 33;  // extended sample, signed
  localparam int RES_W      = 34;  // residual of one predictor, signed
  localparam int SUM_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ROW_LEN_W  = 13;
  localparam int ROW_IDX_W  = 16;
  localparam int PRED_W     = 2;
  localparam int NUM_PRED   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIGNED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_ROWS    = 3'd5;

  typedef enum logic [1:0] {
    MODE_ENCODE = 2'd0,
    MODE_DECODE = 2'd1,
    MODE_SCORE  = 2'd2,
    MODE_PASS   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PRED_LEFT    = 2'd0,
    PRED_UP      = 2'd1,
    PRED_AVERAGE = 2'd2,
    PRED_PAETH   = 2'd3
  } pred_t;

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2,
    WIDTH_32_ALT = 2'd3
  } width_t;

  // One item leaving the prediction stage.
  typedef struct packed {
    logic                           has_res;
    logic                           last;
    logic                           is_score;
    logic                           scored;
    logic [SAMPLE_W-1:0]            value;
    logic [NUM_PRED-1:0][RES_W-1:0] resid;
  } rsp_stage_t;

  function automatic logic [SAMPLE_W-1:0] width_mask(width_t w);
    logic [SAMPLE_W-1:0] m;
    case (w)
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic signed [EXT_W-1:0] extend_raw(logic [SAMPLE_W-1:0] raw,
                                                         width_t w, logic sgn);
    logic signed [EXT_W-1:0] x;
    case (w)
      WIDTH_8:  x = $signed({{25{sgn & raw[7]}}, raw[7:0]});
      WIDTH_16: x = $signed({{17{sgn & raw[15]}}, raw[15:0]});
      default:  x = $signed({sgn & raw[31], raw});
    endcase
    return x;
  endfunction

  function automatic logic signed [EXT_W-1:0] paeth(logic signed [EXT_W-1:0] a,
                                                    logic signed [EXT_W-1:0] b,
                                                    logic signed [EXT_W-1:0] c);
    logic signed [35:0] p;
    logic signed [35:0] da;
    logic signed [35:0] db;
    logic signed [35:0] dc;
    logic signed [EXT_W-1:0] r;
    p  = 36'(a) + 36'(b) - 36'(c);
    da = (p > 36'(a)) ? p - 36'(a) : 36'(a) - p;
    db = (p > 36'(b)) ? p - 36'(b) : 36'(b) - p;
    dc = (p > 36'(c)) ? p - 36'(c) : 36'(c) - p;
    if (da <= db && da <= dc) r = a;
    else if (db <= dc) r = b;
    else r = c;
    return r;
  endfunction

  function automatic logic signed [EXT_W-1:0] predict(pred_t k,
                                                      logic signed [EXT_W-1:0] l,
                                                      logic signed [EXT_W-1:0] u,
                                                      logic signed [EXT_W-1:0] ul);
    logic signed [EXT_W:0]   s;
    logic signed [EXT_W-1:0] r;
    s = $signed({l[EXT_W-1], l}) + $signed({u[EXT_W-1], u});
    // Truncation toward zero: a negative sum is nudged up by one before the shift.
    if (s[EXT_W]) s = s + 34'sd1;
    case (k)
      PRED_LEFT:    r = l;
      PRED_UP:      r = u;
      PRED_AVERAGE: r = EXT_W'(s >>> 1);
      default:      r = paeth(l, u, ul);
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/rsp_ifs.sv
// ----------------------------------------------------------------------------
// Raster spatial predictor channels
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rsp_in_if import rsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last_item;

  modport source (output valid, output sample, output last_item, input ready);
  modport sink   (input valid, input sample, input last_item, output ready);
endinterface

interface rsp_out_if import rsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] result_value;
  logic [PRED_W-1:0]   best_predictor;
  logic                end_of_image;

  modport source (output valid, output result_value, output best_predictor,
                  output end_of_image, input ready);
  modport sink   (input valid, input result_value, input best_predictor,
                  input end_of_image, output ready);
endinterface

interface rsp_cfg_if import rsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/rsp_line_mem.sv
// ----------------------------------------------------------------------------
// Raster spatial predictor line buffer
// Previous-row store with registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module rsp_line_mem import rsp_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [SAMPLE_W-1:0]      wr_data,
  output logic [SAMPLE_W-1:0]      rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_q;
  logic [SAMPLE_W-1:0] fwd_data;
  logic                fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // A read that meets a write to the same entry would see stale data; the
  // written word is kept aside and used instead.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

FILE: hw/rtl/rsp_tail.sv
// ----------------------------------------------------------------------------
// Raster spatial predictor result tail
// Score accumulation, winner selection and the output register.
// ----------------------------------------------------------------------------
module rsp_tail import rsp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsp_stage_t      in_stage,
  rsp_out_if.source       results
);

  // Accumulate stage.
  logic                           b_v;
  rsp_stage_t                     b;
  logic                           b_go;
  logic [NUM_PRED-1:0][SUM_W-1:0] sums;
  logic [NUM_PRED-1:0][SUM_W-1:0] tot;

  // Selection stage.
  logic                           c_v;
  logic                           c_last;
  logic                           c_is_score;
  logic [SAMPLE_W-1:0]            c_value;
  logic [NUM_PRED-1:0][SUM_W-1:0] c_tot;
  logic                           c_go;
  logic                           c_ready;

  // Output register.
  logic                           o_valid;
  logic [SAMPLE_W-1:0]            o_value;
  logic [PRED_W-1:0]              o_best;
  logic                           o_end;
  logic                           o_ready;

  logic [SUM_W-1:0]               min01;
  logic [SUM_W-1:0]               min23;
  logic [PRED_W-1:0]              best01;
  logic [PRED_W-1:0]              best23;
  logic [PRED_W-1:0]              best;

  assign o_ready  = !o_valid || results.ready;
  assign c_go     = c_v && o_ready;
  assign c_ready  = !c_v || o_ready;
  assign b_go     = b_v && (!b.has_res || c_ready);
  assign in_ready = !b_v || b_go;

  always_comb begin
    for (int k = 0; k < NUM_PRED; k++) begin
      logic signed [RES_W-1:0] r;
      logic [RES_W-1:0]        mag;
      r   = $signed(b.resid[k]);
      mag = r[RES_W-1] ? RES_W'(-r) : RES_W'(r);
      tot[k] = b.scored ? sums[k] + SUM_W'(mag) : sums[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v  <= 1'b0;
      sums <= '0;
    end else begin
      if (in_valid && in_ready) begin
        b_v <= 1'b1;
      end else if (b_go) begin
        b_v <= 1'b0;
      end
      if (b_go) begin
        sums <= b.last ? '0 : tot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b <= in_stage;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (b_go && b.has_res) begin
      c_v <= 1'b1;
    end else if (c_go) begin
      c_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b.has_res) begin
      c_last     <= b.last;
      c_is_score <= b.is_score;
      c_value    <= b.value;
      c_tot      <= tot;
    end
  end

  // Strict less-than keeps a tie with the earlier predictor.
  always_comb begin
    best01 = (c_tot[1] < c_tot[0]) ? PRED_W'(PRED_UP) : PRED_W'(PRED_LEFT);
    min01  = (c_tot[1] < c_tot[0]) ? c_tot[1] : c_tot[0];
    best23 = (c_tot[3] < c_tot[2]) ? PRED_W'(PRED_PAETH) : PRED_W'(PRED_AVERAGE);
    min23  = (c_tot[3] < c_tot[2]) ? c_tot[3] : c_tot[2];
    best   = (min23 < min01) ? best23 : best01;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (c_go) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_go) begin
      o_value <= c_is_score ? '0 : c_value;
      o_best  <= c_is_score ? best : PRED_W'(PRED_LEFT);
      o_end   <= c_last;
    end
  end

  assign results.valid          = o_valid;
  assign results.result_value   = o_value;
  assign results.best_predictor = o_best;
  assign results.end_of_image   = o_end;

endmodule

FILE: hw/rtl/raster_spatial_predictor_codec_unit.sv
// ----------------------------------------------------------------------------
// Raster spatial predictor codec
// Left, up, average and Paeth prediction for encode, decode and scoring.
// ----------------------------------------------------------------------------
// Path: prediction, accumulate and selection stages, then the output register.
// Throughput: one sample beat per cycle while results are not stalled; the
// line buffer takes one read and one write per cycle and the decode path
// closes its left-neighbour loop in the prediction stage.
// Reset: synchronous; registers return to their defaults, position, neighbours
// and score sums clear. The line buffer is not cleared and needs no sweep.
module raster_spatial_predictor_codec_unit import rsp_pkg::*; #(
  parameter int MAX_ROW_LENGTH = 4096
) (
  input  logic      clk,
  input  logic      rst,
  rsp_cfg_if.sink   cfg,
  rsp_in_if.sink    pixels,
  rsp_out_if.source results
);

  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam int LW = $clog2(MAX_ROW_LENGTH + 1);

  // Configuration registers.
  mode_t                 mode;
  pred_t                 predictor;
  width_t                sample_width;
  logic                  sample_signed;
  logic [ROW_LEN_W-1:0]  row_length;
  logic [ROW_IDX_W-1:0]  score_rows;

  // Raster position.
  logic [AW-1:0]         col;
  logic [ROW_IDX_W-1:0]  row_idx;
  logic [LW-1:0]         len;
  logic [AW-1:0]         col_eff;
  logic [LW-1:0]         col_inc;
  logic                  accept;

  // Prediction stage.
  logic                  a_v;
  logic                  a_go;
  logic                  a_ready;
  logic [SAMPLE_W-1:0]   a_sample;
  logic                  a_last;
  logic [AW-1:0]         a_col;
  logic                  a_has_left;
  logic                  a_has_up;
  logic                  a_scored;

  logic [SAMPLE_W-1:0]   left;
  logic [SAMPLE_W-1:0]   upleft;
  logic [SAMPLE_W-1:0]   up_mem;
  logic [SAMPLE_W-1:0]   up_raw;
  logic [SAMPLE_W-1:0]   mask;
  logic [SAMPLE_W-1:0]   kept;
  logic signed [EXT_W-1:0] l;
  logic signed [EXT_W-1:0] u;
  logic signed [EXT_W-1:0] ul;
  logic signed [EXT_W-1:0] v;
  logic signed [EXT_W-1:0] pred;
  rsp_stage_t            a_out;

  function automatic logic [RES_W-1:0] pred_sel(int k,
                                                logic signed [EXT_W-1:0] pl,
                                                logic signed [EXT_W-1:0] pu,
                                                logic signed [EXT_W-1:0] pul);
    logic signed [EXT_W-1:0] p;
    p = predict(pred_t'(k[1:0]), pl, pu, pul);
    return {p[EXT_W-1], p};
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_ENCODE;
      predictor     <= PRED_AVERAGE;
      sample_width  <= WIDTH_8;
      sample_signed <= 1'b0;
      row_length    <= ROW_LEN_W'(1);
      score_rows    <= ROW_IDX_W'(2);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODE:          mode          <= mode_t'(cfg.data[1:0]);
        REG_PREDICTOR:     predictor     <= pred_t'(cfg.data[1:0]);
        REG_SAMPLE_WIDTH:  sample_width  <= width_t'(cfg.data[1:0]);
        REG_SAMPLE_SIGNED: sample_signed <= cfg.data[0];
        REG_ROW_LENGTH:    row_length    <= cfg.data[ROW_LEN_W-1:0];
        REG_SCORE_ROWS:    score_rows    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Row length of zero runs as one; lengths beyond the buffer are clamped.
  always_comb begin
    if (row_length == '0) begin
      len = LW'(1);
    end else if (32'(row_length) > 32'(MAX_ROW_LENGTH)) begin
      len = LW'(MAX_ROW_LENGTH);
    end else begin
      len = LW'(row_length);
    end
    col_eff = (LW'(col) >= len) ? '0 : col;
    col_inc = LW'(col_eff) + LW'(1);
  end

  assign accept        = pixels.valid && pixels.ready;
  assign a_go          = a_v && a_ready;
  assign pixels.ready  = !a_v || a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row_idx <= '0;
      a_v     <= 1'b0;
    end else begin
      if (accept) begin
        a_v <= 1'b1;
        if (pixels.last_item) begin
          col     <= '0;
          row_idx <= '0;
        end else if (col_inc >= len) begin
          col <= '0;
          if (row_idx != '1) begin
            row_idx <= row_idx + ROW_IDX_W'(1);
          end
        end else begin
          col <= col_inc[AW-1:0];
        end
      end else if (a_go) begin
        a_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample   <= pixels.sample & width_mask(sample_width);
      a_last     <= pixels.last_item;
      a_col      <= col_eff;
      a_has_left <= col_eff != '0;
      a_has_up   <= row_idx != '0;
      a_scored   <= row_idx < score_rows;
    end
  end

  rsp_line_mem #(
    .DEPTH (MAX_ROW_LENGTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_eff),
    .wr_en   (a_go),
    .wr_addr (a_col),
    .wr_data (kept),
    .rd_data (up_mem)
  );

  always_comb begin
    mask   = width_mask(sample_width);
    up_raw = a_has_up ? up_mem : '0;
    l      = a_has_left ? extend_raw(left, sample_width, sample_signed) : '0;
    u      = a_has_up ? extend_raw(up_raw, sample_width, sample_signed) : '0;
    ul     = (a_has_left && a_has_up) ?
             extend_raw(upleft, sample_width, sample_signed) : '0;
    v      = extend_raw(a_sample, sample_width, sample_signed);
    pred   = predict(predictor, l, u, ul);
    kept   = (mode == MODE_DECODE) ? ((a_sample + pred[SAMPLE_W-1:0]) & mask) : a_sample;

    a_out.has_res  = (mode == MODE_ENCODE) || (mode == MODE_DECODE) ||
                     ((mode == MODE_SCORE) && a_last);
    a_out.last     = a_last;
    a_out.is_score = mode == MODE_SCORE;
    a_out.scored   = (mode == MODE_SCORE) && a_scored;
    a_out.value    = (mode == MODE_ENCODE) ? ((a_sample - pred[SAMPLE_W-1:0]) & mask)
                                           : kept;
    for (int k = 0; k < NUM_PRED; k++) begin
      a_out.resid[k] = RES_W'($signed({v[EXT_W-1], v}) -
                              $signed({pred_sel(k, l, u, ul)}));
    end
  end

  // The item that leaves on the last beat of an image resets the neighbours.
  always_ff @(posedge clk) begin
    if (rst) begin
      left   <= '0;
      upleft <= '0;
    end else if (a_go) begin
      left   <= a_last ? '0 : kept;
      upleft <= a_last ? '0 : up_raw;
    end
  end

  rsp_tail u_tail (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_v),
    .in_ready (a_ready),
    .in_stage (a_out),
    .results  (results)
  );

endmodule

FILE: hw/rtl/rsp_checker.sv
// ----------------------------------------------------------------------------
// Raster spatial predictor port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rsp_checker import rsp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic [SAMPLE_W-1:0] res_value,
  input logic [PRED_W-1:0]   res_best,
  input logic                res_end
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_value) && $stable(res_best) &&
                                $stable(res_end))
    else $error("result payload changed while stalled");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered straight after reset");

  // A winner other than left only appears on an end-of-image score beat.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_best != '0) |-> res_end && (res_value == '0))
    else $error("predictor winner on a beat that is not a score result");

endmodule

bind raster_spatial_predictor_codec_unit rsp_checker u_rsp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_value (results.result_value),
  .res_best  (results.best_predictor),
  .res_end   (results.end_of_image)
);
